>>> rtl/pag_pkg.sv
// shared types, register indexes and constants for the pixel afterglow block
package pag_pkg;

  localparam int unsigned MAX_FRAME_PIXELS_DEF    = 131072;
  localparam int unsigned DECAY_FRACTION_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned FP_W       = 18;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_GREEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_BLUE   = 3'd4;

  localparam logic [FP_W-1:0] FRAME_PIXELS_RESET = 18'd131072;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_INVAL = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef enum logic [1:0] {
    MODE_BYPASS,
    MODE_PASS,
    MODE_GLOW
  } mode_e;

endpackage

>>> rtl/pag_if.sv
// request channels for pixels in and glow results out
interface pag_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;

  modport source (output valid, op, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink (input valid, op, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface pag_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

>>> rtl/pag_ram.sv
// generic single write port ram with registered read
module pag_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pag_glow.sv
// per channel decay of the stored colour and maximum with the current colour
module pag_glow import pag_pkg::*; #(
  parameter int unsigned DECAY_FRACTION_BITS = DECAY_FRACTION_BITS_DEF,
  localparam int unsigned DW = DECAY_FRACTION_BITS + 1
) (
  input  rgb_t          stored_i,
  input  rgb_t          current_i,
  input  logic [DW-1:0] decay_red_i,
  input  logic [DW-1:0] decay_green_i,
  input  logic [DW-1:0] decay_blue_i,
  output rgb_t          glow_o
);

  localparam logic [DW-1:0] DECAY_ONE = DW'(1) << DECAY_FRACTION_BITS;

  function automatic logic [7:0] glow_ch(logic [7:0] s, logic [7:0] c, logic [DW-1:0] d);
    logic [DW-1:0]   dc;
    logic [DW+7:0]   prod;
    logic [8:0]      trail;
    logic [8:0]      m;
    dc    = (d > DECAY_ONE) ? DECAY_ONE : d;
    prod  = (DW+8)'(s) * (DW+8)'(dc);
    trail = prod[DW+7:DECAY_FRACTION_BITS];
    m     = (trail > {1'b0, c}) ? trail : {1'b0, c};
    return m[8] ? 8'hff : m[7:0];
  endfunction

  always_comb begin
    glow_o.red   = glow_ch(stored_i.red, current_i.red, decay_red_i);
    glow_o.green = glow_ch(stored_i.green, current_i.green, decay_green_i);
    glow_o.blue  = glow_ch(stored_i.blue, current_i.blue, decay_blue_i);
  end

endmodule

>>> rtl/pixel_afterglow_decay_max.sv
// top level of the pixel afterglow block: position control, frame store and output stage
//
// Pixels arrive on in_ch with op clear; op set invalidates the stored frame and
// produces no result. Results leave on out_ch, one per pixel, in order.
// Registers must be written on the cfg port only while the block is idle; the block
// itself does not enforce this. Writing frame_pixels invalidates the stored frame and
// restarts the position at zero. Throughput is one pixel per clock unless the receiver
// stalls. The frame store is read at the position of the accepted pixel; its registered
// data is decayed, combined and written back while the result moves into the output
// register. Back to back pixels at the same position take the written value through a
// forwarding register. At reset the store is marked not valid, so the first frame
// passes through and is stored; the store contents need no clearing. The block starts
// disabled, passing pixels unchanged. When the receiver stalls, the output register
// holds, the working stage holds behind it and, once that stage is full, in_ch.ready
// drops in the same cycle.
module pixel_afterglow_decay_max import pag_pkg::*; #(
  parameter int unsigned MAX_FRAME_PIXELS    = MAX_FRAME_PIXELS_DEF,
  parameter int unsigned DECAY_FRACTION_BITS = DECAY_FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pag_in_if.sink                in_ch,
  pag_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW    = $clog2(MAX_FRAME_PIXELS);
  localparam int unsigned LEN_W = (AW + 1 > FP_W) ? AW + 1 : FP_W;
  localparam int unsigned DW    = DECAY_FRACTION_BITS + 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_PIXELS);

  logic            enable_q;
  logic [FP_W-1:0] fp_q;
  logic [DW-1:0]   decay_red_q, decay_green_q, decay_blue_q;
  logic [AW-1:0]   pos_q, pos_d;
  logic            store_valid_q, store_valid_d;

  logic [LEN_W-1:0] len;
  logic [AW-1:0]    pos_eff;
  logic             last;
  logic             in_acc, push;
  mode_e            mode_in;

  logic          s1_valid_q;
  mode_e         s1_mode_q;
  rgb_t          s1_pix_q;
  logic [7:0]    s1_alpha_q;
  logic [AW-1:0] s1_addr_q;
  logic          fwd_hit_q;
  rgb_t          fwd_data_q;
  logic          s1_move, s1_write;
  rgb_t          ram_rdata, stored, glow, result;
  logic [7:0]    result_alpha;
  logic          ram_re;

  logic       out_valid_q;
  rgb_t       out_pix_q;
  logic [7:0] out_alpha_q;

  always_comb begin
    if (fp_q == '0) begin
      len = LEN_W'(1);
    end else if (LEN_W'(fp_q) > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = LEN_W'(fp_q);
    end
    pos_eff = (LEN_W'(pos_q) >= len) ? '0 : pos_q;
    last    = (LEN_W'(pos_eff) + LEN_W'(1)) >= len;
  end

  assign s1_move     = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || s1_move;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign push        = in_acc && (in_ch.op == OP_PIXEL);

  always_comb begin
    if (!enable_q) begin
      mode_in = MODE_BYPASS;
    end else if (!store_valid_q) begin
      mode_in = MODE_PASS;
    end else begin
      mode_in = MODE_GLOW;
    end
  end

  assign ram_re = push && (mode_in == MODE_GLOW);

  always_comb begin
    pos_d         = pos_q;
    store_valid_d = store_valid_q;
    if (cfg_we_i && (cfg_idx_i == REG_FRAME_PIXELS)) begin
      pos_d         = '0;
      store_valid_d = 1'b0;
    end else if (in_acc && (in_ch.op == OP_INVAL)) begin
      pos_d         = '0;
      store_valid_d = 1'b0;
    end else if (push && enable_q) begin
      pos_d = last ? '0 : pos_eff + AW'(1);
      if (last) begin
        store_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      fp_q          <= FRAME_PIXELS_RESET;
      decay_red_q   <= '0;
      decay_green_q <= '0;
      decay_blue_q  <= '0;
      pos_q         <= '0;
      store_valid_q <= 1'b0;
    end else begin
      pos_q         <= pos_d;
      store_valid_q <= store_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENABLE:       enable_q      <= cfg_wdata_i[0];
          REG_FRAME_PIXELS: fp_q          <= FP_W'(cfg_wdata_i);
          REG_DECAY_RED:    decay_red_q   <= DW'(cfg_wdata_i);
          REG_DECAY_GREEN:  decay_green_q <= DW'(cfg_wdata_i);
          REG_DECAY_BLUE:   decay_blue_q  <= DW'(cfg_wdata_i);
          default: ;
        endcase
      end
    end
  end

  pag_ram #(
    .WIDTH ($bits(rgb_t)),
    .DEPTH (MAX_FRAME_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_addr_q),
    .wdata_i (result),
    .re_i    (ram_re),
    .raddr_i (pos_eff),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else if (push) begin
      s1_valid_q <= 1'b1;
      fwd_hit_q  <= s1_write && (s1_addr_q == pos_eff);
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      s1_mode_q  <= mode_in;
      s1_pix_q   <= '{blue: in_ch.in_blue, green: in_ch.in_green, red: in_ch.in_red};
      s1_alpha_q <= in_ch.in_alpha;
      s1_addr_q  <= pos_eff;
      fwd_data_q <= result;
    end
  end

  assign stored = fwd_hit_q ? fwd_data_q : ram_rdata;

  pag_glow #(
    .DECAY_FRACTION_BITS (DECAY_FRACTION_BITS)
  ) u_glow (
    .stored_i      (stored),
    .current_i     (s1_pix_q),
    .decay_red_i   (decay_red_q),
    .decay_green_i (decay_green_q),
    .decay_blue_i  (decay_blue_q),
    .glow_o        (glow)
  );

  always_comb begin
    case (s1_mode_q)
      MODE_GLOW: begin
        result       = glow;
        result_alpha = ALPHA_OPAQUE;
      end
      default: begin
        result       = s1_pix_q;
        result_alpha = s1_alpha_q;
      end
    endcase
  end

  assign s1_write = s1_move && (s1_mode_q != MODE_BYPASS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_pix_q   <= result;
      out_alpha_q <= result_alpha;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.out_red   = out_pix_q.red;
  assign out_ch.out_green = out_pix_q.green;
  assign out_ch.out_blue  = out_pix_q.blue;
  assign out_ch.out_alpha = out_alpha_q;

`ifndef SYNTHESIS
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(pos_q) < len)
    else $error("pixel position beyond frame length");

  a_inval_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_ch.op == OP_INVAL)) |=> (!store_valid_q && (pos_q == '0)))
    else $error("invalidate did not clear store state");

  a_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re && s1_write && (s1_addr_q == pos_eff)) |=> fwd_hit_q)
    else $error("same position write missed by forwarding");

  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ch.ready) |=> s1_valid_q)
    else $error("working stage lost under output stall");
`endif

endmodule

>>> sim/pixel_afterglow_decay_max_tb.sv
// self-checking testbench for the pixel afterglow block with a glow predictor and scoreboard
module pixel_afterglow_decay_max_tb import pag_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_REQUESTS = 118;
  localparam int unsigned HOLD_CYCLES    = 150;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  class glow_scoreboard;
    rgb_t        frame_mem [int unsigned];
    int unsigned position;
    bit          frame_ok;
    bit          glow_on;
    logic [17:0] frame_reg;
    logic [17:0] red_decay;
    logic [17:0] green_decay;
    logic [17:0] blue_decay;
    pix_t        expected_q [$];
    int unsigned errors;
    int unsigned n_checked;
    int unsigned n_glow;
    int unsigned n_pass;
    int unsigned n_bypass;
    int unsigned n_inval;

    function new();
      position  = 0;
      frame_ok  = 1'b0;
      glow_on   = 1'b0;
      frame_reg = FRAME_PIXELS_RESET;
      red_decay = '0;
      green_decay = '0;
      blue_decay  = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ENABLE: glow_on = val[0];
        REG_FRAME_PIXELS: begin
          frame_reg = val;
          frame_ok  = 1'b0;
          position  = 0;
        end
        REG_DECAY_RED:   red_decay   = val;
        REG_DECAY_GREEN: green_decay = val;
        REG_DECAY_BLUE:  blue_decay  = val;
        default: ;
      endcase
    endfunction

    function int unsigned frame_len();
      if (frame_reg == 0) return 1;
      if (frame_reg > MAX_FRAME_PIXELS_DEF) return MAX_FRAME_PIXELS_DEF;
      return 32'(frame_reg);
    endfunction

    function logic [7:0] fade(logic [7:0] old, logic [7:0] cur, logic [17:0] raw);
      logic [16:0] d;
      logic [24:0] trail;
      d = raw[16:0];
      if (d > 17'h10000) d = 17'h10000;
      trail = (25'(old) * 25'(d)) >> DECAY_FRACTION_BITS_DEF;
      if (trail < 25'(cur)) trail = 25'(cur);
      return (trail > 25'd255) ? 8'hff : trail[7:0];
    endfunction

    function void note_request(logic op, pix_t px);
      mode_e       mode;
      int unsigned len;
      pix_t        res;
      rgb_t        old;
      if (op == OP_INVAL) begin
        frame_ok = 1'b0;
        position = 0;
        n_inval++;
        return;
      end
      res = px;
      if (!glow_on) mode = MODE_BYPASS;
      else if (!frame_ok) mode = MODE_PASS;
      else mode = MODE_GLOW;
      if (mode != MODE_BYPASS) begin
        len = frame_len();
        if (position >= len) position = 0;
        if (mode == MODE_GLOW) begin
          old = frame_mem[position];
          res.red   = fade(old.red, px.red, red_decay);
          res.green = fade(old.green, px.green, green_decay);
          res.blue  = fade(old.blue, px.blue, blue_decay);
          res.alpha = ALPHA_OPAQUE;
        end
        frame_mem[position] = '{blue: res.blue, green: res.green, red: res.red};
        if (position + 1 >= len) begin
          frame_ok = 1'b1;
          position = 0;
        end else begin
          position++;
        end
      end
      case (mode)
        MODE_BYPASS: n_bypass++;
        MODE_PASS:   n_pass++;
        default:     n_glow++;
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(pix_t got);
      pix_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: %0d %0d %0d %0d",
               got.red, got.green, got.blue, got.alpha);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.red !== want.red) begin
        $error("out_red expected %0d actual %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("out_green expected %0d actual %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("out_blue expected %0d actual %0d", want.blue, got.blue);
        errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("out_alpha expected %0d actual %0d", want.alpha, got.alpha);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pag_in_if  in_ch ();
  pag_out_if out_ch ();

  glow_scoreboard sb = new();

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_left;

  pixel_afterglow_decay_max dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("pixel_afterglow_decay_max verification failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.out_alpha});
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_request(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] a);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.in_red   <= r;
    in_ch.in_green <= g;
    in_ch.in_blue  <= b;
    in_ch.in_alpha <= a;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_request(op, '{r, g, b, a});
    @(negedge clk_i);
  endtask

  // block idle: no request outstanding, then a short settle for invalidates
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_decay();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 18'h10000;
      2:       return CFG_DATA_W'($urandom_range(18'h3ffff, 18'h10001));
      default: return CFG_DATA_W'($urandom_range(18'h10000));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_frame();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(100, 40));
      2:       return 18'h3ffff;
      default: return CFG_DATA_W'($urandom_range(12, 1));
    endcase
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] en_word;
    logic                  op;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_PIXEL;
    in_ch.in_red   = '0;
    in_ch.in_green = '0;
    in_ch.in_blue  = '0;
    in_ch.in_alpha = '0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_ENABLE;
    cfg_wdata      = '0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    hold_left      = 0;
    rst_ni         = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // disabled after reset, invalidate while disabled
    push_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff);
    push_request(OP_INVAL, 8'hff, 8'h00, 8'hff, 8'h00);
    push_request(OP_PIXEL, 8'h5a, 8'ha5, 8'h0f, 8'hf0);
    finish_phase();

    // two pixel frame, decay of one, zero and above one
    write_reg(REG_ENABLE, 18'd1);
    write_reg(REG_FRAME_PIXELS, 18'd2);
    write_reg(REG_DECAY_RED, 18'h10000);
    write_reg(REG_DECAY_GREEN, 18'h00000);
    write_reg(REG_DECAY_BLUE, 18'h3ffff);
    push_request(OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'h12);
    push_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h34);
    push_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(OP_PIXEL, 8'h01, 8'hc8, 8'h07, 8'h09);
    push_request(OP_INVAL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(OP_PIXEL, 8'h03, 8'h04, 8'h05, 8'h06);
    finish_phase();

    // zero frame size taken as one: back to back at one position
    write_reg(REG_FRAME_PIXELS, 18'd0);
    write_reg(REG_DECAY_GREEN, 18'h08000);
    push_request(OP_PIXEL, 8'hc8, 8'h64, 8'h32, 8'h01);
    push_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    finish_phase();

    // disable leaves the store alone
    write_reg(REG_ENABLE, 18'h3fffe);
    push_request(OP_PIXEL, 8'h09, 8'h09, 8'h09, 8'h09);
    finish_phase();
    write_reg(REG_ENABLE, 18'd1);
    push_request(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h07);
    finish_phase();

    // frame size above the maximum, then the maximum itself
    write_reg(REG_FRAME_PIXELS, 18'd200000);
    push_request(OP_PIXEL, 8'h11, 8'h22, 8'h33, 8'h44);
    push_request(OP_PIXEL, 8'hee, 8'hdd, 8'hcc, 8'hbb);
    finish_phase();
    write_reg(REG_FRAME_PIXELS, FRAME_PIXELS_RESET);
    push_request(OP_PIXEL, 8'h80, 8'h7f, 8'h01, 8'hfe);
    finish_phase();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 49; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 49; end
        default: begin src_idle_pct = 20; snk_stall_pct = 20; end
      endcase
      en_word = CFG_DATA_W'($urandom);
      en_word[0] = ($urandom_range(7) != 0);
      write_reg(REG_ENABLE, en_word);
      write_reg(REG_FRAME_PIXELS, pick_frame());
      write_reg(REG_DECAY_RED, pick_decay());
      write_reg(REG_DECAY_GREEN, pick_decay());
      write_reg(REG_DECAY_BLUE, pick_decay());
      if (ph == 4) begin
        @(posedge clk_i);
        hold_left = HOLD_CYCLES;
        @(negedge clk_i);
      end
      repeat (PHASE_REQUESTS) begin
        op = ($urandom_range(99) < 3) ? OP_INVAL : OP_PIXEL;
        push_request(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      finish_phase();
    end

    $display("covered %0d glow, %0d first-frame and %0d bypass pixels, %0d invalidates",
             sb.n_glow, sb.n_pass, sb.n_bypass, sb.n_inval);
    $display("%0d results checked over %0d random phases, %0d mismatches",
             sb.n_checked, RANDOM_PHASES, sb.errors);
    if (sb.errors == 0) begin
      $display("pixel_afterglow_decay_max verification clean");
    end else begin
      $display("pixel_afterglow_decay_max verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pag_pkg.sv
rtl/pag_if.sv
rtl/pag_ram.sv
rtl/pag_glow.sv
rtl/pixel_afterglow_decay_max.sv
sim/pixel_afterglow_decay_max_tb.sv
